// ===== src/qrdt_pkg.sv =====
// ---------------------------------------------------------------------------
// qrdt_pkg
// Shared types and constants of the quad reload down timer.
// ---------------------------------------------------------------------------
package qrdt_pkg;

    // Number of timers; each owns a 16-byte register window
    localparam int NUM_TIMERS   = 4;
    localparam int STRIDE_BYTES = 16;
    localparam int ADDR_W       = 12;
    localparam int DATA_W       = 32;
    localparam int ABITS_W      = 7;
    localparam int IRQ_W        = 4;
    localparam int SLOT_W       = ADDR_W - $clog2(STRIDE_BYTES);

    localparam logic [ABITS_W-1:0] FULL_WORD_BITS = ABITS_W'(32);
    localparam logic [DATA_W-1:0]  ALL_ONES       = '1;

    // Item kind carried on the input side band
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    // Register slot within one timer window (address bits 3:2)
    typedef enum logic [1:0] {
        REG_COUNT   = 2'd0,
        REG_RELOAD  = 2'd1,
        REG_CONTROL = 2'd2,
        REG_EOI     = 2'd3
    } reg_slot_t;

    // Control register bit positions
    localparam int CTRL_PERIODIC = 0;
    localparam int CTRL_ENABLE   = 1;
    localparam int CTRL_IRQ_EN   = 2;

    // One registered item as seen by the timer bank
    typedef struct packed {
        logic                go;
        logic [1:0]          action;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
        logic [ABITS_W-1:0]  access_bits;
    } bank_req_t;

    // Result of one item, before the output register
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              bad_width;
        logic [IRQ_W-1:0]  irq_lines;
    } bank_rsp_t;

endpackage

// ===== src/qrdt_timer_bank.sv =====
// ---------------------------------------------------------------------------
// qrdt_timer_bank
// Timer state and the combinational update for one tick or bus access.
// ---------------------------------------------------------------------------
module qrdt_timer_bank
    import qrdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bank_req_t req,
    output bank_rsp_t rsp,
    output logic [IRQ_W-1:0] irq_now
);

    logic [DATA_W-1:0] count_reg  [NUM_TIMERS];
    logic [DATA_W-1:0] count_next [NUM_TIMERS];
    logic [DATA_W-1:0] reload_reg  [NUM_TIMERS];
    logic [DATA_W-1:0] reload_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] on_reg, on_next;
    logic [NUM_TIMERS-1:0] periodic_reg, periodic_next;
    logic [NUM_TIMERS-1:0] irq_en_reg, irq_en_next;
    logic [NUM_TIMERS-1:0] pend_reg, pend_next;

    logic       width_ok;
    logic       is_tick;
    logic       do_write;
    logic       do_read;
    logic       aligned;
    reg_slot_t  slot;
    logic [SLOT_W-1:0] timer_sel;

    // Access decode
    always_comb
    begin
        width_ok  = (req.access_bits == FULL_WORD_BITS);
        is_tick   = req.go && (req.action == ACT_TICK);
        do_write  = req.go && (req.action == ACT_WRITE) && width_ok;
        do_read   = (req.action == ACT_READ) && width_ok;
        aligned   = (req.address[1:0] == 2'b00);
        slot      = reg_slot_t'(req.address[3:2]);
        timer_sel = req.address[ADDR_W-1 -: SLOT_W];
    end

    // Next state, read mux, flag and interrupt lines, all timers in parallel
    always_comb
    begin
        logic hit;
        rsp.read_data = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            hit            = aligned && (timer_sel == SLOT_W'(i));
            count_next[i]  = count_reg[i];
            reload_next[i] = reload_reg[i];
            on_next[i]       = on_reg[i];
            periodic_next[i] = periodic_reg[i];
            irq_en_next[i]   = irq_en_reg[i];
            pend_next[i]     = pend_reg[i];

            // Tick: count down, reload on reaching zero
            if (is_tick && on_reg[i])
            begin
                if (count_reg[i] <= DATA_W'(1))
                begin
                    count_next[i] = reload_reg[i];
                    if (!periodic_reg[i])
                        on_next[i] = 1'b0;
                    if (irq_en_reg[i])
                        pend_next[i] = 1'b1;
                end
                else
                begin
                    count_next[i] = count_reg[i] - DATA_W'(1);
                end
            end

            // Register write
            if (do_write && hit)
            begin
                unique case (slot)
                    REG_RELOAD:
                    begin
                        reload_next[i] = req.write_data;
                        count_next[i]  = req.write_data;
                    end
                    REG_CONTROL:
                    begin
                        periodic_next[i] = req.write_data[CTRL_PERIODIC];
                        on_next[i]       = req.write_data[CTRL_ENABLE];
                        irq_en_next[i]   = req.write_data[CTRL_IRQ_EN];
                    end
                    REG_EOI:     pend_next[i] = 1'b0;
                    default:     ;
                endcase
            end

            // Register read
            if (do_read && hit)
            begin
                unique case (slot)
                    REG_COUNT:   rsp.read_data = count_reg[i];
                    REG_RELOAD:  rsp.read_data = reload_reg[i];
                    REG_CONTROL: rsp.read_data = DATA_W'({irq_en_reg[i], on_reg[i],
                                                          periodic_reg[i]});
                    default:     ;
                endcase
            end
        end

        // Flag and interrupt lines after the step
        rsp.bad_width = ((req.action == ACT_WRITE) || (req.action == ACT_READ)) && !width_ok;
        rsp.irq_lines = '0;
        irq_now       = '0;
        for (int i = 0; i < IRQ_W; i++)
        begin
            if (i < NUM_TIMERS)
            begin
                rsp.irq_lines[i] = pend_next[i];
                irq_now[i]       = pend_reg[i];
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i]  <= ALL_ONES;
                reload_reg[i] <= ALL_ONES;
            end
            on_reg       <= '0;
            periodic_reg <= '0;
            irq_en_reg   <= '0;
            pend_reg     <= '0;
        end
        else if (req.go)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i]  <= count_next[i];
                reload_reg[i] <= reload_next[i];
            end
            on_reg       <= on_next;
            periodic_reg <= periodic_next;
            irq_en_reg   <= irq_en_next;
            pend_reg     <= pend_next;
        end
    end

endmodule

// ===== src/quad_reload_down_timer_top.sv =====
// ---------------------------------------------------------------------------
// quad_reload_down_timer_top
// Four reloadable down timers with a register window, one item per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
//  Channel  | Dir | tdata (low bit up)                        | tuser
//  ---------+-----+-------------------------------------------+------------
//  s_axis   | in  | address[11:0] write_data[43:12]           | action[1:0]
//           |     | access_bits[50:44] zero[55:51]            |
//  m_axis   | out | read_data[31:0] irq_lines[35:32] zero[39:36] | bad_width
//
//  An accepted item is held in the input register while the timer bank
//  updates state, and the result is captured in the output register; one
//  item is taken every cycle while the output is not stalled.
//  A stalled output holds the input register; s_tready drops only when both
//  registers are full. Reset clears all timers to count/reload all ones,
//  disabled, one-shot, interrupts off and not pending.
// ---------------------------------------------------------------------------
module quad_reload_down_timer_top
    import qrdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // address, write_data, access_bits, zero fill
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_data, irq_lines, zero fill
    output logic [0:0]  m_tuser    // bad_width
);

    logic              in_valid_reg;
    logic [1:0]        action_reg;
    logic [ADDR_W-1:0] address_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [ABITS_W-1:0] abits_reg;
    logic              out_valid_reg;
    bank_rsp_t         rsp_reg;
    logic              advance;
    bank_req_t         req;
    bank_rsp_t         rsp;
    logic [IRQ_W-1:0]  irq_now;

    // Pipeline control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            action_reg  <= s_tuser;
            address_reg <= s_tdata[11:0];
            wdata_reg   <= s_tdata[43:12];
            abits_reg   <= s_tdata[50:44];
        end
    end

    // Timer bank
    always_comb
    begin
        req.go          = advance;
        req.action      = action_reg;
        req.address     = address_reg;
        req.write_data  = wdata_reg;
        req.access_bits = abits_reg;
    end

    qrdt_timer_bank u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .irq_now (irq_now)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= rsp;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, rsp_reg.irq_lines, rsp_reg.read_data};
    assign m_tuser  = rsp_reg.bad_width;

    // Checks
    a_bad_width_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0)
        else $error("bad width transfer carries read data");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(action_reg))
        else $error("held input item lost");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without full pipeline");

    a_pending_set_by_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (|(irq_now & ~$past(irq_now))) |->
            $past(advance) && ($past(action_reg) == ACT_TICK))
        else $error("interrupt pending set without a tick");

endmodule

// ===== tb/tb_quad_reload_down_timer_top.sv =====
// ---------------------------------------------------------------------------
// tb_quad_reload_down_timer_top
// Self-checking bench for the quad reload down timer. A short table of
// directed ticks and register accesses runs first, then random traffic that
// is mostly ticks and legal programming of the timers with some malformed accesses.
// Each result is compared against its table entry where one is given, else against an in-bench model of the timer bank.
// Random gaps on input and output, plus one long output stall.
// ---------------------------------------------------------------------------
module tb_quad_reload_down_timer_top
    import qrdt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS  = 1700;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 50;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam logic [1:0]  ACT_UNUSED    = 2'd3;
    localparam int          DIRECTED_ROWS = 27;

    // One directed row; rsp is used only when known is set
    typedef struct packed {
        logic [1:0]         act;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  wdata;
        logic [ABITS_W-1:0] abits;
        logic               known;
        bank_rsp_t          rsp;
    } stim_row_t;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // state right after reset
        '{ACT_READ,   12'h000, 32'h0,        7'd32, 1'b1, '{32'hffff_ffff, 1'b0, 4'h0}},
        '{ACT_READ,   12'h034, 32'h0,        7'd32, 1'b1, '{32'hffff_ffff, 1'b0, 4'h0}},
        '{ACT_READ,   12'h018, 32'h0,        7'd32, 1'b1, '{32'h0, 1'b0, 4'h0}},
        '{ACT_READ,   12'h00c, 32'h0,        7'd32, 1'b1, '{32'h0, 1'b0, 4'h0}},
        // wrong access widths
        '{ACT_READ,   12'h000, 32'h0,        7'd16, 1'b1, '{32'h0, 1'b1, 4'h0}},
        '{ACT_WRITE,  12'h004, 32'hffff_ffff, 7'd64, 1'b1, '{32'h0, 1'b1, 4'h0}},
        '{ACT_READ,   12'h004, 32'h0,        7'd1,  1'b1, '{32'h0, 1'b1, 4'h0}},
        // beyond the last timer, unaligned, unused action, idle tick
        '{ACT_READ,   12'hffc, 32'h0,        7'd32, 1'b1, '{32'h0, 1'b0, 4'h0}},
        '{ACT_WRITE,  12'h040, 32'hffff_ffff, 7'd32, 1'b1, '{32'h0, 1'b0, 4'h0}},
        '{ACT_READ,   12'h005, 32'h0,        7'd32, 1'b1, '{32'h0, 1'b0, 4'h0}},
        '{ACT_UNUSED, 12'h004, 32'h1234_5678, 7'd32, 1'b1, '{32'h0, 1'b0, 4'h0}},
        '{ACT_TICK,   12'h000, 32'h0,        7'd0,  1'b1, '{32'h0, 1'b0, 4'h0}},
        // timer 0 periodic with irq, reload 3, count write ignored
        '{ACT_WRITE,  12'h004, 32'h3,        7'd32, 1'b0, '0},
        '{ACT_WRITE,  12'h008, 32'h7,        7'd32, 1'b0, '0},
        '{ACT_WRITE,  12'h000, 32'h0,        7'd32, 1'b0, '0},
        '{ACT_TICK,   12'h000, 32'h0,        7'd0,  1'b0, '0},
        '{ACT_TICK,   12'h000, 32'h0,        7'd0,  1'b0, '0},
        '{ACT_TICK,   12'h000, 32'h0,        7'd0,  1'b0, '0},
        '{ACT_READ,   12'h000, 32'h0,        7'd32, 1'b0, '0},
        '{ACT_WRITE,  12'h00c, 32'h0,        7'd32, 1'b0, '0},
        // timer 1 one-shot from a zero count
        '{ACT_WRITE,  12'h014, 32'h0,        7'd32, 1'b0, '0},
        '{ACT_WRITE,  12'h018, 32'h6,        7'd32, 1'b0, '0},
        '{ACT_TICK,   12'h000, 32'h0,        7'd0,  1'b0, '0},
        '{ACT_READ,   12'h018, 32'h0,        7'd32, 1'b0, '0},
        // timer 3 enabled with junk in the upper control bits
        '{ACT_WRITE,  12'h038, 32'hffff_fffa, 7'd32, 1'b0, '0},
        '{ACT_TICK,   12'h000, 32'h0,        7'd0,  1'b0, '0},
        '{ACT_READ,   12'h030, 32'h0,        7'd32, 1'b0, '0}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // address, write_data, access_bits, zero fill
    logic [1:0]  s_tuser  = '0;   // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // read_data, irq_lines, zero fill
    logic [0:0]  m_tuser;         // bad_width

    // Timer bank model state
    logic [DATA_W-1:0] tmr_count    [NUM_TIMERS];
    logic [DATA_W-1:0] tmr_reload   [NUM_TIMERS];
    bit                tmr_on       [NUM_TIMERS];
    bit                tmr_periodic [NUM_TIMERS];
    bit                tmr_irq_en   [NUM_TIMERS];
    bit                tmr_pending  [NUM_TIMERS];

    bank_rsp_t   expected_results [$];
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned errors       = 0;
    int unsigned cycle_count  = 0;

    quad_reload_down_timer_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Advance the model by one item and return its result
    function automatic bank_rsp_t timer_bank_step(input logic [1:0] act,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [DATA_W-1:0] wdata,
                                                  input logic [ABITS_W-1:0] abits);
        bank_rsp_t   rsp;
        int unsigned idx;
        reg_slot_t   slot;
        bit          decoded;
        rsp     = '0;
        idx     = addr / STRIDE_BYTES;
        slot    = reg_slot_t'(addr[3:2]);
        decoded = (addr[1:0] == 2'b00) && (addr < STRIDE_BYTES * NUM_TIMERS);
        if (act == ACT_TICK)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (tmr_on[i])
                begin
                    if (tmr_count[i] <= 1)
                    begin
                        tmr_count[i] = tmr_reload[i];
                        if (!tmr_periodic[i])
                            tmr_on[i] = 1'b0;
                        if (tmr_irq_en[i])
                            tmr_pending[i] = 1'b1;
                    end
                    else
                        tmr_count[i] = tmr_count[i] - 1;
                end
            end
        end
        else if (act == ACT_WRITE || act == ACT_READ)
        begin
            if (abits != FULL_WORD_BITS)
                rsp.bad_width = 1'b1;
            else if (decoded && act == ACT_WRITE)
            begin
                case (slot)
                    REG_RELOAD:
                    begin
                        tmr_reload[idx] = wdata;
                        tmr_count[idx]  = wdata;
                    end
                    REG_CONTROL:
                    begin
                        tmr_periodic[idx] = wdata[CTRL_PERIODIC];
                        tmr_on[idx]       = wdata[CTRL_ENABLE];
                        tmr_irq_en[idx]   = wdata[CTRL_IRQ_EN];
                    end
                    REG_EOI:
                        tmr_pending[idx] = 1'b0;
                    default: ;
                endcase
            end
            else if (decoded)
            begin
                case (slot)
                    REG_COUNT:  rsp.read_data = tmr_count[idx];
                    REG_RELOAD: rsp.read_data = tmr_reload[idx];
                    REG_CONTROL:
                    begin
                        rsp.read_data[CTRL_PERIODIC] = tmr_periodic[idx];
                        rsp.read_data[CTRL_ENABLE]   = tmr_on[idx];
                        rsp.read_data[CTRL_IRQ_EN]   = tmr_irq_en[idx];
                    end
                    default: ;
                endcase
            end
        end
        for (int i = 0; i < NUM_TIMERS && i < IRQ_W; i++)
            rsp.irq_lines[i] = tmr_pending[i];
        return rsp;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Offer one item, wait for the transfer, record its expected result,
    // then idle for a random gap
    task automatic offer_item(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata,
                              input logic [ABITS_W-1:0] abits,
                              input logic known, input bank_rsp_t known_rsp);
        bank_rsp_t   rsp;
        int unsigned gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'd0, abits, wdata, addr};
        do
            @(posedge clk);
        while (!s_tready);
        rsp = timer_bank_step(act, addr, wdata, abits);
        expected_results.push_back(known ? known_rsp : rsp);
        items_sent++;
        gap = pick_gap(((items_sent / 120) % 4) == 1);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Output side: random stalls, calm stretches, one long hold-off
    initial
    begin
        int unsigned stall;
        bit          held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 400)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                stall = pick_gap(((results_seen / 150) % 4) == 2);
                if (stall == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        bank_rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result read_data=%h irq=%h bad_width=%b",
                         $realtime, m_tdata[31:0], m_tdata[35:32], m_tuser[0]);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $realtime, want.read_data, m_tdata[31:0]);
                    errors++;
                end
                if (m_tuser[0] !== want.bad_width)
                begin
                    $display("%0t: bad_width expected %b actual %b",
                             $realtime, want.bad_width, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[35:32] !== want.irq_lines)
                begin
                    $display("%0t: irq_lines expected %h actual %h",
                             $realtime, want.irq_lines, m_tdata[35:32]);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int unsigned r;
        int unsigned tmr;
        logic [1:0]         act;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  wdata;
        logic [ABITS_W-1:0] abits;
        reg_slot_t          slot;

        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            tmr_count[i]    = ALL_ONES;
            tmr_reload[i]   = ALL_ONES;
            tmr_on[i]       = 1'b0;
            tmr_periodic[i] = 1'b0;
            tmr_irq_en[i]   = 1'b0;
            tmr_pending[i]  = 1'b0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int k = 0; k < DIRECTED_ROWS; k++)
            offer_item(DIRECTED[k].act, DIRECTED[k].addr, DIRECTED[k].wdata,
                       DIRECTED[k].abits, DIRECTED[k].known, DIRECTED[k].rsp);

        // random traffic: mostly ticks and legal timer programming, some noise
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r     = $urandom_range(0, 99);
            tmr   = $urandom_range(0, NUM_TIMERS - 1);
            wdata = $urandom();
            abits = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(0, 127))
                                                 : FULL_WORD_BITS;
            act   = ACT_TICK;
            addr  = 12'($urandom_range(0, 4095));
            if (r < 45)
            begin
                abits = 7'($urandom_range(0, 127));
            end
            else if (r < 65)
            begin
                act = ACT_WRITE;
                case ($urandom_range(0, 9))
                    0:       slot = REG_COUNT;
                    1, 2, 3: slot = REG_RELOAD;
                    4, 5, 6: slot = REG_CONTROL;
                    default: slot = REG_EOI;
                endcase
                if (slot == REG_RELOAD && $urandom_range(0, 9) != 0)
                    wdata = $urandom_range(0, 12);
                addr = 12'(tmr * STRIDE_BYTES) | {8'd0, slot, 2'b00};
            end
            else if (r < 85)
            begin
                act  = ACT_READ;
                slot = reg_slot_t'($urandom_range(0, 3));
                addr = 12'(tmr * STRIDE_BYTES) | {8'd0, slot, 2'b00};
            end
            else
            begin
                act = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 0)
                    addr = 12'($urandom_range(0, STRIDE_BYTES * NUM_TIMERS - 1));
            end
            offer_item(act, addr, wdata, abits, 1'b0, '0);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain, then allow for stray results
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/qrdt_pkg.sv
src/qrdt_timer_bank.sv
src/quad_reload_down_timer_top.sv
tb/tb_quad_reload_down_timer_top.sv
